@@ rtl/gaussian_blur_3x3_rgb_stream_unit_macros.svh @@
// Assertion macros for the 3x3 blur stream unit checker.
// Used by gb3_stream_chk; expects clk and arst_n in scope.
`ifndef GAUSSIAN_BLUR_3X3_RGB_STREAM_UNIT_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_RGB_STREAM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GB3_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GB3_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// Holds at every edge while reset is asserted.
`define GB3_ASSERT_RST(label, cons, msg) \
	label: assert property (@(posedge clk) !arst_n |-> (cons)) else $error(msg);

`endif

@@ rtl/gb3_pkg.sv @@
// Shared types and constants of the 3x3 blur stream unit.
// No dependencies; imported by every module of the block.
package gb3_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_ADDR_W   = 1;
	localparam int SUM_W        = 12;
	localparam int REL_W        = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_W'(1);

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	// Result slots released by one pixel, emitted lowest bit first
	localparam int REL_ABOVE_PREV = 0;
	localparam int REL_ABOVE_EDGE = 1;
	localparam int REL_LAST_PREV  = 2;
	localparam int REL_LAST_EDGE  = 3;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} src_pixel_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_of_run;
		logic       frame_end;
	} dst_pixel_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             first_row;
		logic             last_row;
		logic             last_col;
	} pos_t;

	typedef struct packed {
		rgb_t             top;
		rgb_t             mid;
		rgb_t             bot;
		logic             first_col;
		logic [REL_W-1:0] rel_mask;
	} col_load_t;

endpackage

@@ rtl/gb3_line_buf.sv @@
// Two line stores and the first pipeline stage of the blur unit.
// Depends on gb3_pkg.
module gb3_line_buf import gb3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  rgb_t      pix,
	input  pos_t      pos,
	input  logic      adv,
	output logic      col_valid,
	output col_load_t col
);

	rgb_t upper_mem [MAX_WIDTH];
	rgb_t lower_mem [MAX_WIDTH];

	logic valid_s1;
	rgb_t pix_s1;
	pos_t pos_s1;
	rgb_t up_rd_s1;
	rgb_t lo_rd_s1;
	logic byp_s1;
	rgb_t up_byp_s1;
	rgb_t lo_byp_s1;

	rgb_t up_val;
	rgb_t lo_val;
	rgb_t top_w;
	rgb_t mid_w;
	logic fwd;

	always_comb begin
		up_val = byp_s1 ? up_byp_s1 : up_rd_s1;
		lo_val = byp_s1 ? lo_byp_s1 : lo_rd_s1;
		top_w  = pos_s1.first_row ? pix_s1 : up_val;
		mid_w  = pos_s1.first_row ? pix_s1 : lo_val;
		// write and read hit the same column (one-pixel rows)
		fwd    = adv && (pos_s1.col == pos.col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pix_s1    <= pix;
			pos_s1    <= pos;
			up_rd_s1  <= upper_mem[pos.col];
			lo_rd_s1  <= lower_mem[pos.col];
			byp_s1    <= fwd;
			up_byp_s1 <= mid_w;
			lo_byp_s1 <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			upper_mem[pos_s1.col] <= mid_w;
			lower_mem[pos_s1.col] <= pix_s1;
		end
	end

	always_comb begin
		col_valid     = valid_s1;
		col.top       = top_w;
		col.mid       = mid_w;
		col.bot       = pix_s1;
		col.first_col = (pos_s1.col == '0);
		col.rel_mask[REL_ABOVE_PREV] = !pos_s1.first_row && (pos_s1.col != '0);
		col.rel_mask[REL_ABOVE_EDGE] = !pos_s1.first_row && pos_s1.last_col;
		col.rel_mask[REL_LAST_PREV]  = pos_s1.last_row && (pos_s1.col != '0);
		col.rel_mask[REL_LAST_EDGE]  = pos_s1.last_row && pos_s1.last_col;
	end

endmodule

@@ rtl/gb3_window.sv @@
// 3x3 window, pending-result list, kernel and output register of the blur unit.
// Depends on gb3_pkg.
module gb3_window import gb3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       col_valid,
	input  col_load_t  col,
	output logic       take,
	output logic       res_valid,
	input  logic       res_ready,
	output dst_pixel_t res
);

	rgb_t [2:0]       win_q [3];
	logic [REL_W-1:0] rel_q;
	logic             res_valid_q;
	dst_pixel_t       res_q;

	logic [REL_W-1:0] sel;
	logic [REL_W-1:0] rest;
	logic             res_free;
	logic             emit;
	logic             col_ready;
	logic             at_edge;
	logic             on_last;
	rgb_t [2:0]       colv [3];
	logic [2:0][2:0][7:0] r_taps;
	logic [2:0][2:0][7:0] g_taps;
	logic [2:0][2:0][7:0] b_taps;
	dst_pixel_t       res_d;

	// weights 1-2-1 / 2-4-2 / 1-2-1, then divide by 16
	function automatic logic [7:0] kern(input logic [2:0][2:0][7:0] s);
		logic [SUM_W-1:0] acc;
		acc = SUM_W'(s[0][0]) + SUM_W'(s[0][2]) + SUM_W'(s[2][0]) + SUM_W'(s[2][2])
		    + (SUM_W'(s[0][1]) << 1) + (SUM_W'(s[2][1]) << 1)
		    + (SUM_W'(s[1][0]) << 1) + (SUM_W'(s[1][2]) << 1)
		    + (SUM_W'(s[1][1]) << 2);
		return acc[SUM_W-1:4];
	endfunction

	always_comb begin
		sel       = rel_q & (~rel_q + 1'b1);
		rest      = rel_q & ~sel;
		res_free  = !res_valid_q || res_ready;
		emit      = (rel_q != '0) && res_free;
		col_ready = (rel_q == '0) || (res_free && (rest == '0));
		take      = col_valid && col_ready;
		at_edge   = sel[REL_ABOVE_EDGE] || sel[REL_LAST_EDGE];
		on_last   = sel[REL_LAST_PREV] || sel[REL_LAST_EDGE];

		// right edge repeats the newest column
		colv[0] = at_edge ? win_q[1] : win_q[0];
		colv[1] = at_edge ? win_q[2] : win_q[1];
		colv[2] = win_q[2];

		for (int j = 0; j < 3; j++) begin
			// bottom edge repeats the lowest row
			r_taps[j][0] = on_last ? colv[j][1].red   : colv[j][0].red;
			r_taps[j][1] = on_last ? colv[j][2].red   : colv[j][1].red;
			r_taps[j][2] = colv[j][2].red;
			g_taps[j][0] = on_last ? colv[j][1].green : colv[j][0].green;
			g_taps[j][1] = on_last ? colv[j][2].green : colv[j][1].green;
			g_taps[j][2] = colv[j][2].green;
			b_taps[j][0] = on_last ? colv[j][1].blue  : colv[j][0].blue;
			b_taps[j][1] = on_last ? colv[j][2].blue  : colv[j][1].blue;
			b_taps[j][2] = colv[j][2].blue;
		end

		res_d.red_out     = kern(r_taps);
		res_d.green_out   = kern(g_taps);
		res_d.blue_out    = kern(b_taps);
		res_d.last_of_run = (rest == '0);
		res_d.frame_end   = sel[REL_LAST_EDGE];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q       <= '0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				win_q[k] <= '0;
			end
		end else begin
			if (take) begin
				rel_q <= col.rel_mask;
				if (col.first_col) begin
					for (int k = 0; k < 3; k++) begin
						win_q[k] <= {col.bot, col.mid, col.top};
					end
				end else begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= {col.bot, col.mid, col.top};
				end
			end else if (emit) begin
				rel_q <= rest;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ rtl/gaussian_blur_3x3_rgb_stream_unit.sv @@
// Top level of the 3x3 Gaussian blur stream unit (uses gb3_pkg, gb3_line_buf and
// gb3_window). RGB pixels come in raster order on src and each channel is filtered
// with the 1-2-1 / 2-4-2 / 1-2-1 kernel, summed, divided by 16 and truncated;
// samples outside the frame take the nearest edge pixel. Results leave on dst one
// row and one column behind the input, so a pixel releases zero results (first
// column, or first row unless the frame has one row), one (most pixels), up to
// two (last column, or other pixels of the last row) or up to four (last pixel
// of the frame); last_of_run marks the final result of a pixel and frame_end the
// bottom-right one. The unit takes one pixel per clock while dst is not stalled
// and each pixel releases at most one result; a pixel with several results holds
// back the next pixel while they leave, since the output register issues one
// result per cycle. A result reaches dst through the line store read register,
// the window load and the output register. The user must write image_width and
// image_height through cfg only while the unit is idle; the unit does not enforce
// this. Width is clamped to 1..2048 and a height of zero acts as one. The line
// stores need no clearing after reset: the first row of a frame never reads them.
module gaussian_blur_3x3_rgb_stream_unit import gb3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  src_pixel_t            src_pixel,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output dst_pixel_t            dst_pixel,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;
	logic [COL_W-1:0]        col_q;
	logic [HEIGHT_REG_W-1:0] row_q;

	logic [COL_W-1:0]        last_col_idx;
	logic [HEIGHT_REG_W-1:0] last_row_idx;
	logic                    last_col;
	logic                    last_row;
	logic                    accept;
	rgb_t                    pix;
	pos_t                    pos;
	logic                    lb_valid;
	col_load_t               lb_col;
	logic                    col_take;

	// Configuration registers: plain writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_wdata[WIDTH_REG_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_wdata[HEIGHT_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Last column and row of the frame, with the register values clamped
	always_comb begin
		if (image_width_q == '0) begin
			last_col_idx = '0;
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			last_col_idx = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col_idx = COL_W'(image_width_q - 1'b1);
		end
		last_row_idx = (image_height_q == '0) ? '0 : image_height_q - 1'b1;
		// a position at or past the end counts as the end (after a shrink)
		last_col = (col_q >= last_col_idx);
		last_row = (row_q >= last_row_idx);
	end

	// Accept a new pixel whenever stage one is empty or hands off this cycle
	assign src_ready = !lb_valid || col_take;
	assign accept    = src_valid && src_ready;

	always_comb begin
		pix.red       = src_pixel.red_in;
		pix.green     = src_pixel.green_in;
		pix.blue      = src_pixel.blue_in;
		pos.col       = col_q;
		pos.first_row = (row_q == '0);
		pos.last_row  = last_row;
		pos.last_col  = last_col;
	end

	// Raster position of the next pixel; wrap column at row end, row at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage one: line store read for the column, store write on hand-off
	gb3_line_buf u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.pix       (pix),
		.pos       (pos),
		.adv       (col_take),
		.col_valid (lb_valid),
		.col       (lb_col)
	);

	// Stage two: window shift, release list, kernel and output register
	gb3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (lb_valid),
		.col       (lb_col),
		.take      (col_take),
		.res_valid (dst_valid),
		.res_ready (dst_ready),
		.res       (dst_pixel)
	);

endmodule

@@ rtl/gb3_stream_chk.sv @@
// Port-level checker for the 3x3 blur stream unit, bound to the top level.
// Depends on gb3_pkg and the unit's assertion macro header.
`include "gaussian_blur_3x3_rgb_stream_unit_macros.svh"

module gb3_stream_chk import gb3_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  src_valid,
	input logic                  src_ready,
	input src_pixel_t            src_pixel,
	input logic                  dst_valid,
	input logic                  dst_ready,
	input dst_pixel_t            dst_pixel
);

	// an offered pixel holds until its transfer
	`GB3_ASSERT_NXT(a_src_hold, src_valid && !src_ready, src_valid && $stable(src_pixel), "src moved")

	// a stalled result holds until its transfer
	`GB3_ASSERT_NXT(a_dst_hold, dst_valid && !dst_ready, dst_valid && $stable(dst_pixel), "dst result changed while stalled")

	// the bottom-right result always closes its pixel's run
	`GB3_ASSERT_IMP(a_frame_end_last, dst_valid && dst_pixel.frame_end, dst_pixel.last_of_run, "frame_end without last_of_run")

	// no result is shown while reset is held
	`GB3_ASSERT_RST(a_rst_quiet, !dst_valid, "dst_valid high during reset")

endmodule

bind gaussian_blur_3x3_rgb_stream_unit gb3_stream_chk u_stream_chk (.*);
